// File: src/ulw_pkg.sv
// Shared types and constants for the UTF-8 aware line wrapper.
package ulw_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] CONT_LOW     = 8'h80;
  localparam logic [7:0] CONT_HIGH    = 8'hBF;
  localparam logic [7:0] LEAD3_LOW    = 8'hE0;
  localparam logic [7:0] LEAD3_HIGH   = 8'hEF;

  localparam int unsigned MAX_COL_W  = 10;
  localparam int unsigned COL_CNT_W  = 11;
  localparam int unsigned BUNDLE_LEN = 4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SECOND = 2'd2,
    PH_UNUSED = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_t;

  typedef struct packed {
    phase_e                 phase;
    logic [7:0]             lead_byte;
    logic [7:0]             second_byte;
    logic [COL_CNT_W-1:0]   col_cnt;
  } wrap_state_t;

  // Result bytes caused by one input byte, in output order.
  typedef struct packed {
    logic [BUNDLE_LEN-1:0][7:0] bytes;
    logic [2:0]                 cnt;
  } bundle_t;

  function automatic logic is_cont(input logic [7:0] b);
    return b inside {[CONT_LOW:CONT_HIGH]};
  endfunction

endpackage

// File: src/utf8_aware_line_wrapper.sv
// Top level of the UTF-8 aware line wrapper: wrap state, result bundle and output register.
// An accepted byte's results are registered in the bundle register; its result bytes then move
// one at a time into the output register, from which each one transfers out.
// Throughput: one input byte per cycle while the output is not stalled and each byte yields at
// most one result byte; a byte with more holds the input side until its last result byte moves.
// Reset (rst_ni low, asynchronous) clears the wrap state and both buffers, max_columns is 20.
module utf8_aware_line_wrapper (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ulw_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ulw_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [ulw_pkg::MAX_COL_W-1:0]     cfg_wdata_i
);
  import ulw_pkg::*;

  // Configuration register.
  logic [MAX_COL_W-1:0] max_columns_q;

  // Wrap state carried from one input byte to the next.
  wrap_state_t state_q, state_d;

  // Bundle register: all result bytes of the last accepted input byte.
  bundle_t bundle_d, bundle_q;
  logic    bnd_valid_q, bnd_valid_d;
  logic [1:0] idx_q, idx_d;

  // Output register, one result byte.
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic in_fire;
  logic move;
  logic last_move;

  // The step logic works directly on the incoming byte; its results are
  // registered in the bundle register at the input transfer.
  ulw_step u_step (
    .in_data_i     (in_data_i),
    .state_i       (state_q),
    .max_columns_i (max_columns_q),
    .state_o       (state_d),
    .bundle_o      (bundle_d)
  );

  // A byte moves from the bundle into the output register whenever the output
  // register is empty or its byte is being taken in this cycle.
  assign move      = bnd_valid_q && (!out_valid_q || out_ready_i);
  assign last_move = move && (({1'b0, idx_q} + 3'd1) == bundle_q.cnt);

  // The bundle register is free for a new input byte when it is empty or
  // when its final byte leaves in this cycle.
  assign in_ready_o = !bnd_valid_q || last_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    bnd_valid_d = bnd_valid_q;
    idx_d       = idx_q;
    if (in_fire) begin
      // An input byte that causes no result leaves the bundle register empty.
      bnd_valid_d = (bundle_d.cnt != 3'd0);
      idx_d       = 2'd0;
    end else if (last_move) begin
      bnd_valid_d = 1'b0;
    end else if (move) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (move) begin
      out_valid_d       = 1'b1;
      out_d.out_byte    = bundle_q.bytes[idx_q];
      out_d.run_last    = last_move;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_columns_q <= MAX_COL_W'(20);
      state_q       <= '{phase: PH_IDLE, lead_byte: '0, second_byte: '0, col_cnt: '0};
      bnd_valid_q   <= 1'b0;
      idx_q         <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_columns_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        state_q <= state_d;
      end
      bnd_valid_q <= bnd_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bundle_q <= bundle_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/ulw_step.sv
// Next-state and result-bundle logic for one input byte of the line wrapper.
module ulw_step (
  input  ulw_pkg::in_t                       in_data_i,
  input  ulw_pkg::wrap_state_t               state_i,
  input  logic [ulw_pkg::MAX_COL_W-1:0]      max_columns_i,
  output ulw_pkg::wrap_state_t               state_o,
  output ulw_pkg::bundle_t                   bundle_o
);
  import ulw_pkg::*;

  logic [7:0]           b;
  logic [1:0]           cols;
  logic [COL_CNT_W-1:0] col_sum;
  logic                 wrap;

  assign b = in_data_i.in_byte;

  always_comb begin
    state_o  = state_i;
    bundle_o = '0;
    cols     = 2'd0;

    case (state_i.phase)
      PH_LEAD: begin
        state_o.second_byte = b;
        state_o.phase       = PH_SECOND;
      end
      PH_SECOND: begin
        if (is_cont(state_i.second_byte) && is_cont(b)) begin
          bundle_o.bytes[0] = state_i.lead_byte;
          bundle_o.bytes[1] = state_i.second_byte;
          bundle_o.bytes[2] = b;
          bundle_o.cnt      = 3'd3;
          cols              = 2'd2;
        end
        state_o.phase = PH_IDLE;
      end
      default: begin
        // An unused phase code is treated as no sequence pending.
        state_o.phase = PH_IDLE;
        if (b < CONT_LOW) begin
          bundle_o.bytes[0] = b;
          bundle_o.cnt      = 3'd1;
          cols              = 2'd1;
        end else if (b inside {[LEAD3_LOW:LEAD3_HIGH]}) begin
          state_o.lead_byte = b;
          state_o.phase     = PH_LEAD;
        end
      end
    endcase

    col_sum = state_i.col_cnt + COL_CNT_W'(cols);
    wrap    = (cols != 2'd0) && (col_sum > COL_CNT_W'(max_columns_i));

    if (cols != 2'd0) begin
      state_o.col_cnt = wrap ? '0 : col_sum;
    end
    if (wrap) begin
      bundle_o.bytes[bundle_o.cnt[1:0]] = NEWLINE_BYTE;
      bundle_o.cnt                      = bundle_o.cnt + 3'd1;
    end

    if (in_data_i.text_end) begin
      state_o.phase   = PH_IDLE;
      state_o.col_cnt = '0;
    end
  end

endmodule

// File: sim/ulw_checker.sv
// Scoreboard for the UTF-8 line wrapper: watches both channels, predicts output and compares.
module ulw_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  ulw_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  ulw_pkg::out_t                 out_data_i,
  input  logic                          cfg_we_i,
  input  logic [ulw_pkg::MAX_COL_W-1:0] cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ulw_pkg::*;

  localparam logic [MAX_COL_W-1:0] DEFAULT_LIMIT = 10'd20;
  localparam logic [COL_CNT_W-1:0] ONE_COL       = 11'd1;
  localparam logic [COL_CNT_W-1:0] TWO_COLS      = 11'd2;

  logic [MAX_COL_W-1:0] col_limit;
  phase_e               seq_phase;
  logic [7:0]           lead_hold;
  logic [7:0]           second_hold;
  logic [COL_CNT_W-1:0] col_count;
  out_t                 wrapped_q[$];
  out_t                 want;
  int unsigned          fail_count;

  function automatic bit in_cont_range(logic [7:0] b);
    return (b >= CONT_LOW) && (b <= CONT_HIGH);
  endfunction

  // Adds the width of one character and tells whether the line must be broken.
  function automatic bit add_columns(logic [COL_CNT_W-1:0] cols);
    col_count = col_count + cols;
    if (col_count > {1'b0, col_limit}) begin
      col_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Queues the output bytes that one input byte causes.
  function automatic void wrap_byte(in_t item);
    logic [7:0] burst[$];
    logic [7:0] b;
    out_t       e;
    b = item.in_byte;
    case (seq_phase)
      PH_LEAD: begin
        second_hold = b;
        seq_phase   = PH_SECOND;
      end
      PH_SECOND: begin
        if (in_cont_range(second_hold) && in_cont_range(b)) begin
          burst.push_back(lead_hold);
          burst.push_back(second_hold);
          burst.push_back(b);
          if (add_columns(TWO_COLS)) burst.push_back(NEWLINE_BYTE);
        end
        seq_phase = PH_IDLE;
      end
      default: begin
        seq_phase = PH_IDLE;
        if (b < CONT_LOW) begin
          burst.push_back(b);
          if (add_columns(ONE_COL)) burst.push_back(NEWLINE_BYTE);
        end else if (b >= LEAD3_LOW && b <= LEAD3_HIGH) begin
          lead_hold = b;
          seq_phase = PH_LEAD;
        end
      end
    endcase
    if (item.text_end) begin
      seq_phase = PH_IDLE;
      col_count = '0;
    end
    foreach (burst[i]) begin
      e.out_byte = burst[i];
      e.run_last = (i == burst.size() - 1);
      wrapped_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_limit   = DEFAULT_LIMIT;
      seq_phase   = PH_IDLE;
      lead_hold   = '0;
      second_hold = '0;
      col_count   = '0;
      fail_count  = 0;
      wrapped_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (wrapped_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output byte %02h run_last %0b, nothing expected",
                   $time, out_data_i.out_byte, out_data_i.run_last);
        end else begin
          want = wrapped_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            fail_count++;
            $display("%0t: out_byte expected %02h, actual %02h",
                     $time, want.out_byte, out_data_i.out_byte);
          end
          if (out_data_i.run_last !== want.run_last) begin
            fail_count++;
            $display("%0t: run_last expected %0b, actual %0b (byte %02h)",
                     $time, want.run_last, out_data_i.run_last, want.out_byte);
          end
        end
      end
      // A byte taken at the same edge as a register write still sees the old limit.
      if (in_valid_i && in_ready_i) wrap_byte(in_data_i);
      if (cfg_we_i) col_limit = cfg_wdata_i;
    end
    fail_count_o <= fail_count;
    pending_o    <= wrapped_q.size();
  end

endmodule

// File: sim/tb_utf8_aware_line_wrapper.sv
// Top-level testbench for the UTF-8 line wrapper: stimulus, handshake idling and verdict.
module tb_utf8_aware_line_wrapper;
  timeunit 1ns;
  timeprecision 1ps;
  import ulw_pkg::*;

  // Minimum number of accepted bytes per random phase.
  localparam int unsigned PHASE_ITEMS   = 58;
  // Cycles the receiver holds off during the backpressure phase.
  localparam int unsigned HOLD_CYCLES   = 40;
  // Cycles allowed after the last expected byte for the block to go quiet.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [MAX_COL_W-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;

  // Idling switch shared by both sides; some phases run with no gaps at all.
  bit          gaps_on  = 1'b1;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;

  always #1 clk = ~clk;

  utf8_aware_line_wrapper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ulw_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one byte and returns at the edge where its transfer happens. The
  // task is entered at a rising edge, so any gap starts right after the
  // previous transfer, and valid is only touched once per time step.
  task automatic send_byte(logic [7:0] b, logic text_end);
    int unsigned gap;
    in_t         item;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.in_byte  = b;
    item.text_end = text_end;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // A text-end mark on roughly one byte in twenty.
  function automatic logic end_draw();
    return ($urandom_range(0, 19) == 0);
  endfunction

  // Sends one random run. Most runs are well formed: ASCII characters or
  // complete three-byte sequences with random content. The rest are
  // sequences with a random tail and stray bytes of any value.
  task automatic send_random_run();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_byte(8'($urandom_range(0, 8'h7F)), end_draw());
    end else if (pick < 8) begin
      send_byte(8'($urandom_range(LEAD3_LOW, LEAD3_HIGH)), end_draw());
      send_byte(8'($urandom_range(CONT_LOW, CONT_HIGH)), end_draw());
      send_byte(8'($urandom_range(CONT_LOW, CONT_HIGH)), end_draw());
    end else if (pick == 8) begin
      send_byte(8'($urandom_range(LEAD3_LOW, LEAD3_HIGH)), end_draw());
      send_byte(8'($urandom_range(0, 255)), end_draw());
      send_byte(8'($urandom_range(0, 255)), end_draw());
    end else begin
      send_byte(8'($urandom_range(0, 255)), end_draw());
    end
  endtask

  // Stops offering bytes and waits until every predicted byte has come out.
  // A held lead byte produces nothing, so a few extra cycles cover work that
  // the scoreboard cannot see.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only happen with the block drained.
  task automatic write_limit(logic [MAX_COL_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: draws a stall before each transfer, or a long hold-off when
  // asked, which lets the output buffer fill and backs up the input side.
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 8) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int unsigned          phase_start;
    logic [MAX_COL_W-1:0] lim;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the limit still at its reset value.
    // ASCII extremes.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // Smallest and largest well-formed three-byte sequences.
    send_byte(LEAD3_LOW, 1'b0);
    send_byte(CONT_LOW, 1'b0);
    send_byte(CONT_LOW, 1'b0);
    send_byte(LEAD3_HIGH, 1'b0);
    send_byte(CONT_HIGH, 1'b0);
    send_byte(CONT_HIGH, 1'b0);
    // Sequence with an ASCII second byte: all three bytes vanish.
    send_byte(8'hE5, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b0);
    // Sequence whose third byte is just above the continuation range.
    send_byte(8'hE5, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);
    // Stray bytes with the top bit set that do not start a sequence.
    send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Sequence cut off by the end of the text: the held bytes are lost.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h80, 1'b1);

    // A limit of zero breaks the line after every counted character.
    write_limit('0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hE3, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h82, 1'b1);

    // Random phases, each under its own limit. No text end is forced between
    // phases, so a lowered limit often meets a count already above it.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       lim = 10'd1023;
        1:       lim = 10'd2;
        2:       lim = '0;
        3:       lim = 10'd7;
        4:       lim = 10'($urandom_range(1, 40));
        default: lim = 10'd20;
      endcase
      write_limit(lim);
      // Two phases run back to back with no idling; the second of them also
      // carries the long receiver hold-off while the sender keeps pushing.
      gaps_on  = (p != 2) && (p != 3);
      hold_req = (p == 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) send_random_run();
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

endmodule
